### rtl/core/pidc_pkg.sv
// Shared types and constants of the PID controller with anti-windup.
// Depends on nothing; every other file of the block depends on it.
package pidc_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_IDX_W      = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_SETPOINT   = 3'd3,
      CSR_PERIOD     = 3'd4,
      CSR_OUTPUT_MAX = 3'd5,
      CSR_OUTPUT_MIN = 3'd6,
      CSR_WEAKEN     = 3'd7
   } pidc_csr_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2
   } pidc_clamp_type;

   // Shared by the bit-serial multiplier and divider.
   typedef enum logic [1:0] {
      U_IDLE,
      U_RUN,
      U_FIN
   } pidc_unit_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_IMAX,
      S_IMIN,
      S_INC,
      S_CURI,
      S_DIFF,
      S_PTERM,
      S_ITERM,
      S_DTERM,
      S_CLAMP,
      S_WEAK,
      S_OUT
   } pidc_state_type;

endpackage

### rtl/core/pidc_if.sv
// Channel interfaces of the PID controller: request, response and register write.
// Depends on pidc_pkg for default widths.
interface pidc_req_if #(parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] feedback;
   modport source (output valid, output feedback, input ready);
   modport sink (input valid, input feedback, output ready);
endinterface

interface pidc_rsp_if #(parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] control_out;
   logic [1:0]                   clamp_state;
   modport source (output valid, output control_out, output clamp_state, input ready);
   modport sink (input valid, input control_out, input clamp_state, output ready);
endinterface

interface pidc_csr_if #(parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF);
   logic                             valid;
   logic                             ready;
   logic [pidc_pkg::CSR_IDX_W-1:0]   index;
   logic [DATA_WIDTH-1:0]            data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/pidc_mul.sv
// Bit-serial fixed-point multiplier: one multiplier bit per cycle, then
// shift by the fraction bits and saturate. Depends on pidc_pkg.
module pidc_mul #(
   parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] op_a,
   input  logic signed [DATA_WIDTH-1:0] op_b,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] result
);
   import pidc_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int CNT_W = $clog2(W + 1);
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

   pidc_unit_state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [W-1:0]        x_ff, x_in;
   logic [W:0]          hi_ff, hi_in;
   logic [W-1:0]        lo_ff, lo_in;
   logic                neg_ff, neg_in;

   logic [W-1:0]        mag_a, mag_b;
   logic [W:0]          sum;
   logic [2*W-1:0]      prod;
   logic [2*W-F-1:0]    r;

   assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
   assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;
   assign sum   = hi_ff + (lo_ff[0] ? {1'b0, x_ff} : {(W+1){1'b0}});
   assign prod  = {hi_ff[W-1:0], lo_ff};
   assign r     = prod[2*W-1:F];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: if (start) state_in = U_RUN;
         U_RUN: if (cnt_ff == CNT_W'(1)) state_in = U_FIN;
         U_FIN: state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == U_FIN);
      result = {W{1'b0}};
      if (neg_ff) begin
         if ((|r[2*W-F-1:W]) || (r[W-1] && (|r[W-2:0]))) result = SMIN;
         else result = ~r[W-1:0] + 1'b1;
      end else begin
         if (|r[2*W-F-1:W-1]) result = SMAX;
         else result = r[W-1:0];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      x_in   = x_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      neg_in = neg_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               x_in   = mag_a;
               lo_in  = mag_b;
               hi_in  = {(W+1){1'b0}};
               cnt_in = CNT_W'(W);
               neg_in = op_a[W-1] ^ op_b[W-1];
            end
         end
         U_RUN: begin
            hi_in  = {1'b0, sum[W:1]};
            lo_in  = {sum[0], lo_ff[W-1:1]};
            cnt_in = cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= U_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      neg_ff <= neg_in;
   end

endmodule

### rtl/core/pidc_div.sv
// Bit-serial restoring divider for (a << FRAC_BITS) / b, one quotient bit per
// cycle, truncated toward zero and saturated. Depends on pidc_pkg.
module pidc_div #(
   parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] op_a,
   input  logic signed [DATA_WIDTH-1:0] op_b,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] result
);
   import pidc_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int QW    = W + F;
   localparam int CNT_W = $clog2(QW + 1);
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

   pidc_unit_state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [QW-1:0]       dq_ff, dq_in;
   logic [W:0]          rem_ff, rem_in;
   logic [W-1:0]        y_ff, y_in;
   logic                neg_ff, neg_in;
   logic                bz_ff, bz_in;
   logic                an_ff, an_in;
   logic                anz_ff, anz_in;

   logic [W-1:0]        mag_a, mag_b;
   logic [W:0]          trial;
   logic                ge;

   assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
   assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;
   assign trial = {rem_ff[W-1:0], dq_ff[QW-1]};
   assign ge    = (trial >= {1'b0, y_ff});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: if (start) state_in = (op_b == '0) ? U_FIN : U_RUN;
         U_RUN: if (cnt_ff == CNT_W'(1)) state_in = U_FIN;
         U_FIN: state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == U_FIN);
      result = {W{1'b0}};
      if (bz_ff) begin
         if (an_ff) result = SMIN;
         else if (anz_ff) result = SMAX;
      end else if (neg_ff) begin
         if ((|dq_ff[QW-1:W]) || (dq_ff[W-1] && (|dq_ff[W-2:0]))) result = SMIN;
         else result = ~dq_ff[W-1:0] + 1'b1;
      end else begin
         if (|dq_ff[QW-1:W-1]) result = SMAX;
         else result = dq_ff[W-1:0];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      dq_in  = dq_ff;
      rem_in = rem_ff;
      y_in   = y_ff;
      neg_in = neg_ff;
      bz_in  = bz_ff;
      an_in  = an_ff;
      anz_in = anz_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               dq_in  = {mag_a, {F{1'b0}}};
               rem_in = {(W+1){1'b0}};
               y_in   = mag_b;
               cnt_in = CNT_W'(QW);
               neg_in = op_a[W-1] ^ op_b[W-1];
               bz_in  = (op_b == '0);
               an_in  = op_a[W-1];
               anz_in = (op_a != '0);
            end
         end
         U_RUN: begin
            rem_in = ge ? (trial - {1'b0, y_ff}) : trial;
            dq_in  = {dq_ff[QW-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= U_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      y_ff   <= y_in;
      neg_ff <= neg_in;
      bz_ff  <= bz_in;
      an_ff  <= an_in;
      anz_ff <= anz_in;
   end

endmodule

### rtl/core/pid_controller_anti_windup.sv
// The divisions (up to three) and multiplies (up to five) of a request run one after
// another on the shared bit-serial units. A new request is taken only while idle; the
// next request is taken while a result waits in the output register.
// Reset (synchronous): registers to defaults, integral and last error to zero.
module pid_controller_anti_windup #(
   parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pidc_req_if.sink    req_if,
   pidc_rsp_if.source  rsp_if,
   pidc_csr_if.sink    csr_if
);
   import pidc_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int F = FRAC_BITS;
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-2:0] PERIOD_RST = (W-1)'(1) << F;
   localparam logic [F:0]   WEAKEN_RST = (F+1)'(1) << (F - 1);

   // Saturate a one-bit-wider sum to the data range.
   function automatic logic signed [W-1:0] sat_w(input logic [W:0] v);
      logic signed [W-1:0] r;
      if (v[W] != v[W-1]) r = v[W] ? SMIN : SMAX;
      else r = v[W-1:0];
      return r;
   endfunction

   // Configuration registers
   logic [W-2:0]        gain_p_ff, gain_p_in;
   logic [W-2:0]        gain_i_ff, gain_i_in;
   logic [W-2:0]        gain_d_ff, gain_d_in;
   logic signed [W-1:0] setpoint_ff, setpoint_in;
   logic [W-2:0]        period_ff, period_in;
   logic signed [W-1:0] output_max_ff, output_max_in;
   logic signed [W-1:0] output_min_ff, output_min_in;
   logic [F:0]          weaken_ff, weaken_in;

   // Controller state and per-request working registers
   pidc_state_type      state_ff, state_in;
   logic                launched_ff, launched_in;
   logic                first_run_ff, first_run_in;
   logic signed [W-1:0] last_error_ff, last_error_in;
   logic signed [W-1:0] integral_ff, integral_in;
   logic signed [W-1:0] fb_ff, fb_in;
   logic signed [W-1:0] err_ff, err_in;
   logic signed [W-1:0] imax_ff, imax_in;
   logic signed [W-1:0] imin_ff, imin_in;
   logic signed [W-1:0] inc_ff, inc_in;
   logic signed [W-1:0] cur_i_ff, cur_i_in;
   logic signed [W-1:0] diff_ff, diff_in;
   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] co_ff, co_in;
   pidc_clamp_type      clamp_ff, clamp_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] control_out_ff, control_out_in;
   pidc_clamp_type      clamp_state_ff, clamp_state_in;

   // Shared arithmetic units
   logic                mul_start, mul_done;
   logic signed [W-1:0] mul_a, mul_b, mul_res;
   logic                div_start, div_done;
   logic signed [W-1:0] div_a, div_b, div_res;

   logic                req_take;
   logic signed [W-1:0] err_calc, avg, curi_raw, curi_clip, diff_op;
   logic signed [W:0]   err_sum, err_half;
   logic                use_diff, clamp_hi, clamp_lo, need_weak, slot_free;

   pidc_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   pidc_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .op_a   (div_a),
      .op_b   (div_b),
      .done   (div_done),
      .result (div_res)
   );

   assign req_take  = req_if.valid && req_if.ready;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign use_diff  = (gain_d_ff != '0) && !first_run_ff;

   // Error, trapezoid average (halved toward zero), integral candidate
   assign err_calc  = sat_w({setpoint_ff[W-1], setpoint_ff} - {fb_ff[W-1], fb_ff});
   assign err_sum   = {last_error_ff[W-1], last_error_ff} + {err_ff[W-1], err_ff};
   assign err_half  = (err_sum + (W+1)'(err_sum[W])) >>> 1;
   assign avg       = err_half[W-1:0];
   assign curi_raw  = sat_w({integral_ff[W-1], integral_ff} + {inc_ff[W-1], inc_ff});
   assign curi_clip = (curi_raw > imax_ff) ? imax_ff :
                      ((curi_raw < imin_ff) ? imin_ff : curi_raw);
   assign diff_op   = sat_w({err_ff[W-1], err_ff} - {last_error_ff[W-1], last_error_ff});

   // Output limits: the high check wins when the limits cross. Weaken the stored
   // integral unless the increment points back into range.
   assign clamp_hi  = (acc_ff >= output_max_ff);
   assign clamp_lo  = !clamp_hi && (acc_ff <= output_min_ff);
   assign need_weak = (clamp_hi && !(inc_ff < 0)) || (clamp_lo && !(inc_ff > 0));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_take) state_in = S_ERR;
         S_ERR: begin
            if (gain_i_ff != '0) state_in = S_IMAX;
            else if (use_diff) state_in = S_DIFF;
            else state_in = S_PTERM;
         end
         S_IMAX: if (div_done) state_in = S_IMIN;
         S_IMIN: if (div_done) state_in = S_INC;
         S_INC: if (mul_done) state_in = S_CURI;
         S_CURI: state_in = use_diff ? S_DIFF : S_PTERM;
         S_DIFF: if (div_done) state_in = S_PTERM;
         S_PTERM: if (mul_done) state_in = S_ITERM;
         S_ITERM: if (mul_done) state_in = S_DTERM;
         S_DTERM: if (mul_done) state_in = S_CLAMP;
         S_CLAMP: state_in = need_weak ? S_WEAK : S_OUT;
         S_WEAK: if (mul_done) state_in = S_OUT;
         S_OUT: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshakes, unit launches and operand select
   always_comb begin
      req_if.ready = (state_ff == S_IDLE);
      csr_if.ready = 1'b1;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_a        = '0;
      div_b        = '0;
      case (state_ff)
         S_IMAX: begin
            div_start = !launched_ff;
            div_a     = output_max_ff;
            div_b     = {1'b0, gain_i_ff};
         end
         S_IMIN: begin
            div_start = !launched_ff;
            div_a     = output_min_ff;
            div_b     = {1'b0, gain_i_ff};
         end
         S_INC: begin
            mul_start = !launched_ff;
            mul_a     = avg;
            mul_b     = {1'b0, period_ff};
         end
         S_DIFF: begin
            div_start = !launched_ff;
            div_a     = diff_op;
            div_b     = {1'b0, period_ff};
         end
         S_PTERM: begin
            mul_start = !launched_ff;
            mul_a     = {1'b0, gain_p_ff};
            mul_b     = err_ff;
         end
         S_ITERM: begin
            mul_start = !launched_ff;
            mul_a     = {1'b0, gain_i_ff};
            mul_b     = cur_i_ff;
         end
         S_DTERM: begin
            mul_start = !launched_ff;
            mul_a     = {1'b0, gain_d_ff};
            mul_b     = diff_ff;
         end
         S_WEAK: begin
            mul_start = !launched_ff;
            mul_a     = integral_ff;
            mul_b     = {{(W-F-1){1'b0}}, weaken_ff};
         end
         default: ;
      endcase
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.control_out = control_out_ff;
   assign rsp_if.clamp_state = clamp_state_ff;

   // Configuration writes
   always_comb begin
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      setpoint_in   = setpoint_ff;
      period_in     = period_ff;
      output_max_in = output_max_ff;
      output_min_in = output_min_ff;
      weaken_in     = weaken_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_GAIN_P:     gain_p_in     = csr_if.data[W-2:0];
            CSR_GAIN_I:     gain_i_in     = csr_if.data[W-2:0];
            CSR_GAIN_D:     gain_d_in     = csr_if.data[W-2:0];
            CSR_SETPOINT:   setpoint_in   = csr_if.data;
            CSR_PERIOD:     period_in     = csr_if.data[W-2:0];
            CSR_OUTPUT_MAX: output_max_in = csr_if.data;
            CSR_OUTPUT_MIN: output_min_in = csr_if.data;
            CSR_WEAKEN:     weaken_in     = csr_if.data[F:0];
            default: ;
         endcase
      end
   end

   // Datapath: capture each unit result as its step finishes
   always_comb begin
      launched_in    = launched_ff;
      first_run_in   = first_run_ff;
      last_error_in  = last_error_ff;
      integral_in    = integral_ff;
      fb_in          = fb_ff;
      err_in         = err_ff;
      imax_in        = imax_ff;
      imin_in        = imin_ff;
      inc_in         = inc_ff;
      cur_i_in       = cur_i_ff;
      diff_in        = diff_ff;
      acc_in         = acc_ff;
      co_in          = co_ff;
      clamp_in       = clamp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      control_out_in = control_out_ff;
      clamp_state_in = clamp_state_ff;

      // Mark a unit busy on launch, free it when its result lands.
      if (mul_start || div_start) launched_in = 1'b1;
      if (mul_done || div_done) launched_in = 1'b0;

      case (state_ff)
         S_IDLE: if (req_take) fb_in = req_if.feedback;
         S_ERR: begin
            err_in   = err_calc;
            inc_in   = '0;
            cur_i_in = '0;
            diff_in  = '0;
         end
         S_IMAX: if (div_done) imax_in = div_res;
         S_IMIN: if (div_done) imin_in = div_res;
         S_INC: if (mul_done) inc_in = mul_res;
         S_CURI: cur_i_in = curi_clip;
         S_DIFF: if (div_done) diff_in = div_res;
         S_PTERM: if (mul_done) acc_in = mul_res;
         S_ITERM, S_DTERM: begin
            if (mul_done) acc_in = sat_w({acc_ff[W-1], acc_ff} + {mul_res[W-1], mul_res});
         end
         S_CLAMP: begin
            first_run_in  = 1'b0;
            last_error_in = err_ff;
            if (clamp_hi) begin
               co_in    = output_max_ff;
               clamp_in = CLAMP_HIGH;
            end else if (clamp_lo) begin
               co_in    = output_min_ff;
               clamp_in = CLAMP_LOW;
            end else begin
               co_in    = acc_ff;
               clamp_in = CLAMP_NONE;
            end
            // Hold the old integral for the weakening multiply.
            if (!need_weak) integral_in = cur_i_ff;
         end
         S_WEAK: if (mul_done) integral_in = mul_res;
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               control_out_in = co_ff;
               clamp_state_in = clamp_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launched_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         first_run_ff  <= 1'b1;
         last_error_ff <= '0;
         integral_ff   <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         setpoint_ff   <= '0;
         period_ff     <= PERIOD_RST;
         output_max_ff <= '0;
         output_min_ff <= '0;
         weaken_ff     <= WEAKEN_RST;
      end else begin
         state_ff      <= state_in;
         launched_ff   <= launched_in;
         rsp_valid_ff  <= rsp_valid_in;
         first_run_ff  <= first_run_in;
         last_error_ff <= last_error_in;
         integral_ff   <= integral_in;
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         setpoint_ff   <= setpoint_in;
         period_ff     <= period_in;
         output_max_ff <= output_max_in;
         output_min_ff <= output_min_in;
         weaken_ff     <= weaken_in;
      end
   end

   always_ff @(posedge clock) begin
      fb_ff          <= fb_in;
      err_ff         <= err_in;
      imax_ff        <= imax_in;
      imin_ff        <= imin_in;
      inc_ff         <= inc_in;
      cur_i_ff       <= cur_i_in;
      diff_ff        <= diff_in;
      acc_ff         <= acc_in;
      co_ff          <= co_in;
      clamp_ff       <= clamp_in;
      control_out_ff <= control_out_in;
      clamp_state_ff <= clamp_state_in;
   end

   // A request always starts the error step next.
   a_req_to_err: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_ERR))
      else $error("request not followed by error step");

   // The two serial units never launch together.
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiplier and divider launched together");

   // A high clamp reports the upper limit.
   a_clamp_hi_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (clamp_state_ff == CLAMP_HIGH)) |-> (control_out_ff == output_max_ff))
      else $error("high clamp without upper limit on output");

   // Do not overwrite a waiting result.
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && rsp_valid_ff && !rsp_if.ready) |=> (state_ff == S_OUT))
      else $error("result loaded over a pending response");

endmodule

### dv/pid_controller_anti_windup_tb.sv
// Self-checking testbench of pid_controller_anti_windup: Q16.16 PID steps with clamping.
// Depends on pidc_pkg and the channel interfaces in pidc_if.sv.
module pid_controller_anti_windup_tb;
   import pidc_pkg::*;

   localparam longint Q_MAX     = 64'sd2147483647;
   localparam longint Q_MIN     = -64'sd2147483648;
   localparam int     PHASES    = 9;
   localparam int     PER_PHASE = 148;
   localparam int     SETTLE    = 400;
   localparam longint LIMIT     = 3000000;

   typedef struct {
      logic signed [31:0] control_out;
      pidc_clamp_type     clamp_state;
   } pid_result_type;

   logic clock;
   logic reset;

   pidc_req_if req_if ();
   pidc_rsp_if rsp_if ();
   pidc_csr_if csr_if ();

   pid_controller_anti_windup uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Controller registers and loop state as the predictor sees them.
   longint kp, ki, kd, target, dt, lim_hi, lim_lo, weaken;
   longint prev_err, integ;
   bit     first_step;

   logic signed [31:0] feedback_q[$];
   pid_result_type     control_q[$];
   int  req_idle_pct, rsp_idle_pct, phase_no, fail_count;
   int  queued_count, taken_count, hold_left;
   bit  hold_done, req_fire;
   longint cycle_count;

   initial begin
      clock = 1'b0;
   end
   always begin
      #6 clock = ~clock;
   end

   function automatic longint sat_q(longint v);
      return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
   endfunction

   // Operands never exceed 32 bits here, so magnitudes multiply exactly in 64 bits.
   function automatic longint fx_mul(longint a, longint b);
      longint ma, mb, m;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m  = (ma * mb) >>> 16;
      return sat_q(((a < 0) != (b < 0)) ? -m : m);
   endfunction

   function automatic longint fx_div(longint a, longint b);
      longint ma, mb, m;
      if (b == 0) begin
         return a > 0 ? Q_MAX : (a < 0 ? Q_MIN : 0);
      end
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m  = (ma << 16) / mb;
      return sat_q(((a < 0) != (b < 0)) ? -m : m);
   endfunction

   // Advance the loop state by one sample and return the clamped output.
   function automatic pid_result_type pid_step(logic signed [31:0] fb);
      longint err, incr, cur_i, dterm, co, avg, imax, imin;
      pid_result_type r;
      err   = sat_q(target - longint'(fb));
      incr  = 0;
      cur_i = 0;
      dterm = 0;
      if (ki > 0) begin
         avg   = sat_q((prev_err + err) / 2);
         imax  = fx_div(lim_hi, ki);
         imin  = fx_div(lim_lo, ki);
         incr  = fx_mul(avg, dt);
         cur_i = sat_q(integ + incr);
         if (cur_i > imax) cur_i = imax;
         else if (cur_i < imin) cur_i = imin;
      end
      if (kd > 0 && !first_step) dterm = fx_div(sat_q(err - prev_err), dt);
      co = sat_q(fx_mul(kp, err) + fx_mul(ki, cur_i));
      co = sat_q(co + fx_mul(kd, dterm));
      // High check first, so inverted limits clamp high.
      if (co >= lim_hi) begin
         r.clamp_state = CLAMP_HIGH;
         integ = incr < 0 ? cur_i : fx_mul(integ, weaken);
         co = lim_hi;
      end else if (co <= lim_lo) begin
         r.clamp_state = CLAMP_LOW;
         integ = incr > 0 ? cur_i : fx_mul(integ, weaken);
         co = lim_lo;
      end else begin
         r.clamp_state = CLAMP_NONE;
         integ = cur_i;
      end
      first_step = 1'b0;
      prev_err = err;
      r.control_out = co[31:0];
      return r;
   endfunction

   // Request side: hold the offered request until taken, then advance or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_fire) begin
         req_if.valid <= 1'b1;
      end else if (feedback_q.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
         req_if.valid    <= 1'b1;
         req_if.feedback <= feedback_q.pop_front();
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Response side: random stalls, plus one long hold-off in phase four so the
   // block backs up and stops taking requests.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (phase_no == 4 && !hold_done) begin
         hold_done    <= 1'b1;
         hold_left    <= 3000;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Sample both channels at the rising edge; predict on request, check on response.
   always @(posedge clock) begin
      pid_result_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("pid_controller_anti_windup regression: fail");
         $finish;
      end
      req_fire = !reset && req_if.valid && req_if.ready;
      if (req_fire) begin
         control_q.push_back(pid_step(req_if.feedback));
         taken_count = taken_count + 1;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (control_q.size() == 0) begin
            $error("unexpected response control_out=%0d", rsp_if.control_out);
            fail_count = fail_count + 1;
         end else begin
            want = control_q.pop_front();
            if (rsp_if.control_out !== want.control_out) begin
               $error("control_out expected %0d actual %0d",
                      want.control_out, rsp_if.control_out);
               fail_count = fail_count + 1;
            end
            if (rsp_if.clamp_state !== want.clamp_state) begin
               $error("clamp_state expected %0d actual %0d",
                      want.clamp_state, rsp_if.clamp_state);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // Write one register and mirror it into the predictor once accepted.
   task automatic csr_write(pidc_csr_type idx, logic [31:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_GAIN_P:     kp     = value & 32'h7fff_ffff;
         CSR_GAIN_I:     ki     = value & 32'h7fff_ffff;
         CSR_GAIN_D:     kd     = value & 32'h7fff_ffff;
         CSR_SETPOINT:   target = longint'($signed(value));
         CSR_PERIOD:     dt     = value & 32'h7fff_ffff;
         CSR_OUTPUT_MAX: lim_hi = longint'($signed(value));
         CSR_OUTPUT_MIN: lim_lo = longint'($signed(value));
         CSR_WEAKEN:     weaken = value & 32'h0001_ffff;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_regs(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                            logic [31:0] sp, logic [31:0] per, logic [31:0] hi,
                            logic [31:0] lo, logic [31:0] wk);
      csr_write(CSR_GAIN_P, p);
      csr_write(CSR_GAIN_I, i);
      csr_write(CSR_GAIN_D, d);
      csr_write(CSR_SETPOINT, sp);
      csr_write(CSR_PERIOD, per);
      csr_write(CSR_OUTPUT_MAX, hi);
      csr_write(CSR_OUTPUT_MIN, lo);
      csr_write(CSR_WEAKEN, wk);
   endtask

   task automatic add_sample(logic signed [31:0] fb);
      feedback_q.push_back(fb);
      queued_count = queued_count + 1;
   endtask

   // Drain: every request taken and answered, then let the block settle.
   task automatic drain();
      while (taken_count != queued_count || control_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly a tracking loop around the setpoint; some wild samples mixed in.
   function automatic logic signed [31:0] pick_sample();
      int sel;
      sel = $urandom_range(9);
      if (sel < 6) return 32'(target) + $signed($urandom_range(2 * 262144) - 262144);
      if (sel < 8) return $urandom();
      return sel == 8 ? 32'sh7fff_ffff : 32'sh8000_0000;
   endfunction

   initial begin
      int n;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.feedback = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_GAIN_P;
      csr_if.data = '0;
      req_idle_pct = 26;
      rsp_idle_pct = 69;
      phase_no = 0;
      fail_count = 0;
      queued_count = 0;
      taken_count = 0;
      hold_left = 0;
      hold_done = 1'b0;
      req_fire = 1'b0;
      cycle_count = 0;
      kp = 0; ki = 0; kd = 0; target = 0; dt = 65536;
      lim_hi = 0; lim_lo = 0; weaken = 32768;
      prev_err = 0; integ = 0; first_step = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset defaults first, then extremes and the corner rules.
      add_sample(32'sd0);
      add_sample(32'sh7fff_ffff);
      drain();
      load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h000a_0000,
                32'h0001_0000, 32'h0064_0000, 32'hff9c_0000, 32'h0000_8000);
      add_sample(32'sh0000_0000);
      add_sample(32'sh000a_0000);
      add_sample(32'sh0014_0000);
      add_sample(32'sh8000_0000);
      add_sample(32'sh8000_0000);
      add_sample(32'sh7fff_ffff);
      drain();
      // Zero period, full-scale gains, inverted limits, weaken above unity.
      load_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_ffff);
      add_sample(32'sh7fff_ffff);
      add_sample(32'sh0000_0001);
      add_sample(32'sh8000_0000);
      add_sample(32'sh8000_0000);
      drain();
      // Integral disabled, output exactly on the limits, weaken at zero.
      load_regs(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff,
                32'h0000_0001, 32'h0001_0000, 32'hffff_0000, 32'h0000_0000);
      add_sample(32'sh7ffe_ffff);
      add_sample(32'sh8000_ffff);
      add_sample(32'sh7fff_ffff);
      drain();
      load_regs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
      add_sample(32'sh0001_0000);
      add_sample(32'shffff_0000);
      add_sample(32'sh5555_5555);
      add_sample(32'shaaaa_aaaa);
      drain();

      // Random phases: receiver idles more first, then sender, then neither.
      for (int ph = 0; ph < PHASES; ph++) begin
         phase_no = ph;
         req_idle_pct = ph < 3 ? 26 : (ph < 6 ? 69 : 0);
         rsp_idle_pct = ph < 3 ? 69 : (ph < 6 ? 26 : 0);
         if (ph % 3 == 2) begin
            load_regs($urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom());
         end else begin
            load_regs($urandom_range(32'h0004_0000), ($urandom_range(3) == 0) ? 0 :
                      $urandom_range(32'h0002_0000), ($urandom_range(3) == 0) ? 0 :
                      $urandom_range(32'h0001_0000), $urandom_range(32'h00c8_0000)
                      - 32'h0064_0000, $urandom_range(32'h0002_0000, 32'h0000_4000),
                      $urandom_range(32'h0100_0000, 32'h0001_0000),
                      -$urandom_range(32'h0100_0000, 32'h0001_0000),
                      $urandom_range(65536));
         end
         n = PER_PHASE;
         for (int k = 0; k < n; k++) add_sample(pick_sample());
         drain();
      end

      if (fail_count == 0) begin
         $display("pid_controller_anti_windup regression: pass");
      end else begin
         $display("pid_controller_anti_windup regression: fail");
      end
      $finish;
   end

endmodule
